FILE: design/hse_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hse_pkg: shared types for the Huffman stream encoder
// Holds the transfer payloads of both channels and the action codes.
// ---------------------------------------------------------------------------
package hse_pkg;

  // Field widths of the channel payloads.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned CODE_W   = 32;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PAD_W    = 3;

  // Action codes carried by an input transfer.
  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2
  } hse_action_e;

  // One input item.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SYMBOL_W-1:0] symbol;
    logic [CODE_W-1:0]   code_value;
    logic [LEN_W-1:0]    code_length;
  } hse_in_t;

  // One result item.
  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic              last_of_run;
    logic [PAD_W-1:0]  pad_count;
    logic              missing_code;
  } hse_out_t;

endpackage : hse_pkg
`default_nettype wire

FILE: design/huffman_stream_encoder_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// huffman_stream_encoder_core: Huffman encoder with byte packing
// A code table in block memory, a lookup stage and a byte emitter that
// holds the pending bits and sends one packed byte per cycle while not stalled.
// ---------------------------------------------------------------------------
// Path: a missing-code or flush result goes through the lookup stage and
//   the output register; an encode adds the byte emitter between them.
// Throughput: one item per cycle while the output is not stalled, except that
//   the next item waits while the emitter holds bytes for the one-byte output port.
// Reset: all valid marks, the pending bits and both stages are cleared at
//   once; the code memory holds no reset and is gated by the valid marks.

module huffman_stream_encoder_core import hse_pkg::*; #(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire hse_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output hse_out_t      out_data_o
);

  // Derived sizes.
  localparam int unsigned CodeW = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int unsigned IdxW  = $clog2(SYMBOL_COUNT);
  localparam int unsigned AccW  = CodeW + BYTE_W - 1;
  localparam int unsigned CntW  = $clog2(CodeW + 2 * BYTE_W);
  localparam int unsigned EntW  = CodeW + LEN_W;

  localparam logic [LEN_W-1:0]    LenLim  = LEN_W'(CodeW);
  localparam logic [SYMBOL_W:0]   SymCnt  = (SYMBOL_W + 1)'(SYMBOL_COUNT);
  localparam logic [CntW-1:0]     ByteCnt = CntW'(BYTE_W);
  localparam logic [CntW-1:0]     TwoByte = CntW'(2 * BYTE_W);

  // Input side decode.
  logic            in_fire;
  logic            in_range;
  logic [IdxW-1:0] in_idx;
  logic            do_load;
  logic            do_enter;
  logic [LEN_W-1:0] len_sat;
  logic [CodeW-1:0] code_mask;
  logic [EntW-1:0]  wr_entry;

  assign in_fire  = in_valid_i & ~in_stall_o;
  assign in_range = {1'b0, in_data_i.symbol} < SymCnt;
  assign in_idx   = in_data_i.symbol[IdxW-1:0];

  always_comb begin
    do_load  = 1'b0;
    do_enter = 1'b0;
    unique case (in_data_i.action)
      ACT_LOAD:   do_load  = in_fire & in_range;
      ACT_ENCODE: do_enter = in_fire;
      ACT_FLUSH:  do_enter = in_fire;
      default: begin
        do_load  = 1'b0;
        do_enter = 1'b0;
      end
    endcase
  end

  // Length saturation and masking of code bits above the length.
  assign len_sat   = (in_data_i.code_length > LenLim) ? LenLim : in_data_i.code_length;
  assign code_mask = ~({CodeW{1'b1}} << len_sat);
  assign wr_entry  = {in_data_i.code_value[CodeW-1:0] & code_mask, len_sat};

  // Code table memory: written on load, read on encode and flush.
  logic [EntW-1:0] code_mem [SYMBOL_COUNT];
  logic [EntW-1:0] rd_entry_q;

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      code_mem[in_idx] <= wr_entry;
    end
    if (do_enter) begin
      rd_entry_q <= code_mem[in_idx];
    end
  end

  // Valid marks live in flip-flops so reset clears them at once.
  logic [SYMBOL_COUNT-1:0] vmark_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmark_q <= '0;
    end else if (do_load) begin
      vmark_q[in_idx] <= (len_sat != '0);
    end
  end

  // Lookup stage registers.
  logic s1_valid_q, s1_valid_d;
  logic s1_flush_q;
  logic s1_hit_q;
  logic s1_adv;

  // Byte emitter state: pending bits and their count.
  logic [AccW-1:0] acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] cnt_eff;
  logic            emit_go;
  logic            out_ready;

  // Output register.
  logic     out_valid_q, out_valid_d;
  hse_out_t out_data_q, out_data_d;

  logic [CodeW-1:0] rd_code;
  logic [LEN_W-1:0] rd_len;
  logic [AccW-1:0]  emit_shift;
  logic [AccW-1:0]  flush_shift;

  assign rd_code = rd_entry_q[EntW-1:LEN_W];
  assign rd_len  = rd_entry_q[LEN_W-1:0];

  assign out_ready = ~out_valid_q | ~out_stall_i;
  assign emit_go   = (cnt_q >= ByteCnt) & out_ready;
  assign cnt_eff   = emit_go ? (cnt_q - ByteCnt) : cnt_q;

  // Stage advance: an encode with a code needs the emitter drained; a missing
  // code, or a flush with bits pending, also needs the output slot.
  always_comb begin
    s1_adv = 1'b0;
    if (s1_valid_q) begin
      if (s1_flush_q) begin
        s1_adv = (cnt_q < ByteCnt) & ((cnt_q == '0) | out_ready);
      end else if (s1_hit_q) begin
        s1_adv = cnt_eff < ByteCnt;
      end else begin
        s1_adv = (cnt_q < ByteCnt) & out_ready;
      end
    end
  end

  assign in_stall_o = s1_valid_q & ~s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (do_enter) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_flush_q <= 1'b0;
      s1_hit_q   <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (do_enter) begin
        s1_flush_q <= (in_data_i.action == ACT_FLUSH);
        s1_hit_q   <= in_range & vmark_q[in_idx];
      end
    end
  end

  // Emitter update: append a code, clear on flush, or drop an emitted byte.
  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (s1_adv && !s1_flush_q && s1_hit_q) begin
      acc_d = (acc_q << rd_len) | AccW'(rd_code);
      cnt_d = cnt_eff + CntW'(rd_len);
    end else if (s1_adv && s1_flush_q) begin
      cnt_d = '0;
    end else if (emit_go) begin
      cnt_d = cnt_q - ByteCnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  // Result selection: emitted byte, flush byte or missing-code result.
  assign emit_shift  = acc_q >> (cnt_q - ByteCnt);
  assign flush_shift = acc_q << (ByteCnt - cnt_q);

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_ready) begin
      out_valid_d = 1'b0;
      if (emit_go) begin
        out_valid_d              = 1'b1;
        out_data_d.packed_byte   = emit_shift[BYTE_W-1:0];
        out_data_d.last_of_run   = cnt_q < TwoByte;
        out_data_d.pad_count     = '0;
        out_data_d.missing_code  = 1'b0;
      end else if (s1_adv && s1_flush_q && (cnt_q != '0)) begin
        out_valid_d              = 1'b1;
        out_data_d.packed_byte   = flush_shift[BYTE_W-1:0];
        out_data_d.last_of_run   = 1'b1;
        out_data_d.pad_count     = PAD_W'(ByteCnt - cnt_q);
        out_data_d.missing_code  = 1'b0;
      end else if (s1_adv && !s1_flush_q && !s1_hit_q) begin
        out_valid_d              = 1'b1;
        out_data_d.packed_byte   = '0;
        out_data_d.last_of_run   = 1'b1;
        out_data_d.pad_count     = '0;
        out_data_d.missing_code  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule : huffman_stream_encoder_core
`default_nettype wire
